FILE: rtl/tcl_pkg.sv
// ============================================================================
// tcl_pkg: shared types and constants of the text command line parser
// Command and drive mode codes, keyword table and the per-line result record.
// ============================================================================
`default_nettype none

package tcl_pkg;

    localparam int KW_COUNT = 6;

    // Command codes, as reported on command_code.
    localparam logic [2:0] CMD_NO_MATCH = 3'd0;
    localparam logic [2:0] CMD_STOP     = 3'd1;
    localparam logic [2:0] CMD_OFF      = 3'd2;
    localparam logic [2:0] CMD_CW       = 3'd3;
    localparam logic [2:0] CMD_CCW      = 3'd4;
    localparam logic [2:0] CMD_GETSPEED = 3'd5;
    localparam logic [2:0] CMD_SETSPEED = 3'd6;

    // Drive mode codes.
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_STOP = 2'd1;
    localparam logic [1:0] MODE_CW   = 2'd2;
    localparam logic [1:0] MODE_CCW  = 2'd3;

    // Byte values with a meaning to the parser.
    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    // Keyword text, right-justified in 64 bits, first character highest.
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("stop"), 64'("off"), 64'("cw"), 64'("ccw"),
        64'("getspeed"), 64'("setspeed")
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd4, 4'd3, 4'd2, 4'd3, 4'd8, 4'd8};

    typedef enum logic [1:0] {
        NUM_SKIP,
        NUM_SIGNED,
        NUM_DIGITS,
        NUM_DONE
    } num_phase_t;

    typedef struct packed {
        logic [2:0]  command_code;
        logic [1:0]  drive_mode;
        logic [15:0] speed_value;
        logic        speed_valid;
        logic        line_truncated;
    } line_result_t;

    // Character of keyword k at position pos; pos must be below its length.
    function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
        logic [63:0] w;
        int          sh;
        w  = KW_TEXT[k];
        sh = 8 * (int'(KW_LEN[k]) - 1 - int'(pos));
        if (sh < 0)
            return 8'd0;
        return w[sh +: 8];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tcl_parse_core.sv
// ============================================================================
// tcl_parse_core: per-byte line parser
// Holds the line state, matches the command word, accumulates the argument
// and keeps the drive mode. Builds the line result when a line ends.
// ============================================================================
`default_nettype none

module tcl_parse_core #(
    parameter int LINE_BUFFER_BYTES = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  byte_fire,
    input  wire logic [7:0]            rx_byte,
    output      logic                  line_done,
    output      tcl_pkg::line_result_t line_res
);

    localparam int CNT_W = (LINE_BUFFER_BYTES > 2) ? $clog2(LINE_BUFFER_BYTES) : 1;
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(LINE_BUFFER_BYTES - 1);

    logic [CNT_W-1:0]        char_count_reg, char_count_next;
    logic                    in_argument_reg, in_argument_next;
    logic                    string_ended_reg, string_ended_next;
    logic [tcl_pkg::KW_COUNT-1:0] alive_reg, alive_next;
    tcl_pkg::num_phase_t     phase_reg, phase_next;
    logic                    negative_reg, negative_next;
    logic [15:0]             accum_reg, accum_next;
    logic [1:0]              mode_reg, mode_next;

    logic [CMP_W-1:0]        pos;
    logic [tcl_pkg::KW_COUNT-1:0] len_match;
    logic [tcl_pkg::KW_COUNT-1:0] char_match;
    logic [tcl_pkg::KW_COUNT-1:0] final_alive;
    logic [2:0]              code;
    logic                    is_digit;
    logic                    is_space;
    logic                    full;
    logic                    line_end;

    assign pos      = CMP_W'(char_count_reg);
    assign full     = (char_count_reg >= FULL_COUNT);
    assign line_end = (rx_byte == tcl_pkg::CHAR_NL) || full;
    assign is_digit = (rx_byte >= tcl_pkg::CHAR_ZERO) && (rx_byte <= tcl_pkg::CHAR_NINE);
    assign is_space = (rx_byte == tcl_pkg::CHAR_SPACE) ||
                      ((rx_byte >= tcl_pkg::CHAR_TAB) && (rx_byte <= tcl_pkg::CHAR_CR));

    always_comb
    begin
        for (int k = 0; k < tcl_pkg::KW_COUNT; k++)
        begin
            len_match[k]  = (pos == CMP_W'(tcl_pkg::KW_LEN[k]));
            char_match[k] = (pos < CMP_W'(tcl_pkg::KW_LEN[k])) &&
                            (tcl_pkg::kw_char(k, pos[2:0]) == rx_byte);
        end
    end

    // Command word closes at line end only if no space or zero closed it.
    always_comb
    begin
        final_alive = alive_reg;
        if (!string_ended_reg && !in_argument_reg)
            final_alive = alive_reg & len_match;
        code = tcl_pkg::CMD_NO_MATCH;
        for (int k = tcl_pkg::KW_COUNT - 1; k >= 0; k--)
        begin
            if (final_alive[k])
                code = 3'(k + 1);
        end
    end

    always_comb
    begin
        char_count_next   = char_count_reg;
        in_argument_next  = in_argument_reg;
        string_ended_next = string_ended_reg;
        alive_next        = alive_reg;
        phase_next        = phase_reg;
        negative_next     = negative_reg;
        accum_next        = accum_reg;
        mode_next         = mode_reg;
        line_done         = 1'b0;

        line_res.command_code   = code;
        line_res.drive_mode     = mode_reg;
        line_res.speed_value    = 16'd0;
        line_res.speed_valid    = (code == tcl_pkg::CMD_SETSPEED);
        line_res.line_truncated = (rx_byte != tcl_pkg::CHAR_NL);

        case (code)
            tcl_pkg::CMD_STOP:     mode_next = tcl_pkg::MODE_STOP;
            tcl_pkg::CMD_OFF:      mode_next = tcl_pkg::MODE_OFF;
            tcl_pkg::CMD_CW:       mode_next = tcl_pkg::MODE_CW;
            tcl_pkg::CMD_CCW:      mode_next = tcl_pkg::MODE_CCW;
            tcl_pkg::CMD_SETSPEED: line_res.speed_value = negative_reg ? (16'd0 - accum_reg)
                                                                      : accum_reg;
            default:               mode_next = mode_reg;
        endcase
        line_res.drive_mode = mode_next;

        if (!byte_fire)
        begin
            mode_next = mode_reg;
        end
        else if (line_end)
        begin
            line_done         = 1'b1;
            char_count_next   = '0;
            in_argument_next  = 1'b0;
            string_ended_next = 1'b0;
            alive_next        = '1;
            phase_next        = tcl_pkg::NUM_SKIP;
            negative_next     = 1'b0;
            accum_next        = 16'd0;
        end
        else
        begin
            mode_next       = mode_reg;
            char_count_next = char_count_reg + CNT_W'(1);
            if (!string_ended_reg)
            begin
                if (rx_byte == tcl_pkg::CHAR_NUL)
                begin
                    if (!in_argument_reg)
                        alive_next = alive_reg & len_match;
                    string_ended_next = 1'b1;
                end
                else if (!in_argument_reg)
                begin
                    if (rx_byte == tcl_pkg::CHAR_SPACE)
                    begin
                        alive_next       = alive_reg & len_match;
                        in_argument_next = 1'b1;
                    end
                    else
                    begin
                        alive_next = alive_reg & char_match;
                    end
                end
                else
                begin
                    // A byte that is neither whitespace nor a sign is taken
                    // as the first candidate digit in the same step.
                    case (phase_reg)
                        tcl_pkg::NUM_SKIP:
                        begin
                            if (is_space)
                                phase_next = tcl_pkg::NUM_SKIP;
                            else if ((rx_byte == tcl_pkg::CHAR_PLUS) ||
                                     (rx_byte == tcl_pkg::CHAR_MINUS))
                            begin
                                negative_next = (rx_byte == tcl_pkg::CHAR_MINUS);
                                phase_next    = tcl_pkg::NUM_SIGNED;
                            end
                            else if (is_digit)
                            begin
                                accum_next = (accum_reg << 3) + (accum_reg << 1) +
                                             16'(rx_byte - tcl_pkg::CHAR_ZERO);
                                phase_next = tcl_pkg::NUM_DIGITS;
                            end
                            else
                                phase_next = tcl_pkg::NUM_DONE;
                        end
                        tcl_pkg::NUM_SIGNED, tcl_pkg::NUM_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                accum_next = (accum_reg << 3) + (accum_reg << 1) +
                                             16'(rx_byte - tcl_pkg::CHAR_ZERO);
                                phase_next = tcl_pkg::NUM_DIGITS;
                            end
                            else
                                phase_next = tcl_pkg::NUM_DONE;
                        end
                        default: phase_next = phase_reg;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg   <= '0;
            in_argument_reg  <= 1'b0;
            string_ended_reg <= 1'b0;
            alive_reg        <= '1;
            phase_reg        <= tcl_pkg::NUM_SKIP;
            negative_reg     <= 1'b0;
            accum_reg        <= 16'd0;
            mode_reg         <= tcl_pkg::MODE_OFF;
        end
        else
        begin
            char_count_reg   <= char_count_next;
            in_argument_reg  <= in_argument_next;
            string_ended_reg <= string_ended_next;
            alive_reg        <= alive_next;
            phase_reg        <= phase_next;
            negative_reg     <= negative_next;
            accum_reg        <= accum_next;
            mode_reg         <= mode_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tcl_out_stage.sv
// ============================================================================
// tcl_out_stage: result register
// Holds one finished line result until the consumer takes it.
// ============================================================================
`default_nettype none

module tcl_out_stage (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire tcl_pkg::line_result_t load_res,
    output      logic                  accept_ok,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      tcl_pkg::line_result_t out_res
);

    logic                  valid_reg, valid_next;
    tcl_pkg::line_result_t res_reg;

    // A new byte may enter whenever the slot is empty or drains this cycle.
    assign accept_ok  = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= load_res;
    end

endmodule

`default_nettype wire

FILE: rtl/text_command_line_parser.sv
// ============================================================================
// text_command_line_parser: motor command line parser
// A line's result is registered and appears in the cycle after the byte that ends the line.
// Throughput: one byte per cycle while in_ready is high; the parser state updates in a single pass.
// in_ready drops only while a finished result waits in the output register.
// Reset clears the line state and sets the drive mode to off.
// ============================================================================
`default_nettype none

module text_command_line_parser #(
    parameter int LINE_BUFFER_BYTES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [7:0]  rx_byte,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [2:0]  command_code,
    output      logic [1:0]  drive_mode,
    output      logic [15:0] speed_value,
    output      logic        speed_valid,
    output      logic        line_truncated
);

    logic                  byte_fire;
    logic                  line_done;
    tcl_pkg::line_result_t line_res;
    tcl_pkg::line_result_t out_res;

    assign byte_fire = in_valid && in_ready;

    tcl_parse_core #(
        .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_fire (byte_fire),
        .rx_byte   (rx_byte),
        .line_done (line_done),
        .line_res  (line_res)
    );

    tcl_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (line_done),
        .load_res  (line_res),
        .accept_ok (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign command_code   = out_res.command_code;
    assign drive_mode     = out_res.drive_mode;
    assign speed_value    = out_res.speed_value;
    assign speed_valid    = out_res.speed_valid;
    assign line_truncated = out_res.line_truncated;

endmodule

`default_nettype wire

FILE: rtl/tcl_checker.sv
// ============================================================================
// tcl_checker: port-level checks of the command line parser
// Watches the top-level ports and flags result or flow-control slips.
// ============================================================================
`default_nettype none

module tcl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  command_code,
    input wire logic [1:0]  drive_mode,
    input wire logic [15:0] speed_value,
    input wire logic        speed_valid
);

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(command_code) &&
        $stable(drive_mode) && $stable(speed_value))
    else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> speed_valid == (command_code == tcl_pkg::CMD_SETSPEED))
    else $error("speed_valid disagrees with command_code");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !speed_valid |-> speed_value == 16'd0)
    else $error("speed_value nonzero without setspeed");

    // Input is held off only by a pending, untaken result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

    // A stop command always leaves the drive in stop mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command_code == tcl_pkg::CMD_STOP |-> drive_mode == tcl_pkg::MODE_STOP)
    else $error("stop command did not set stop mode");

endmodule

bind text_command_line_parser tcl_checker u_tcl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .command_code (command_code),
    .drive_mode   (drive_mode),
    .speed_value  (speed_value),
    .speed_valid  (speed_valid)
);

`default_nettype wire

FILE: tb/line_parser_check_pkg.sv
// ============================================================================
// line_parser_check_pkg: scoreboard of the text command line parser bench
// Tracks the parser state byte by byte and holds the line results that are
// due, then compares each result leaving the block against the oldest one.
// ============================================================================

package line_parser_check_pkg;

    import tcl_pkg::*;

    localparam int LINE_BUFFER_BYTES = 64;

    // Keyword text in command order; index k reports command code k + 1.
    function automatic string keyword_name(input int k);
        case (k)
            0:       return "stop";
            1:       return "off";
            2:       return "cw";
            3:       return "ccw";
            4:       return "getspeed";
            default: return "setspeed";
        endcase
    endfunction

    class line_parser_scoreboard;

        int           errors;
        line_result_t line_results_due[$];

        string        kw_word [KW_COUNT];
        logic [2:0]   kw_cmd  [KW_COUNT];

        int           char_count;
        bit           in_arg;
        bit           str_ended;
        logic [5:0]   alive;
        num_phase_t   phase;
        bit           negative;
        logic [15:0]  accum;
        logic [1:0]   mode;

        function new();
            for (int k = 0; k < KW_COUNT; k++)
            begin
                kw_word[k] = keyword_name(k);
            end
            kw_cmd = '{CMD_STOP, CMD_OFF, CMD_CW, CMD_CCW, CMD_GETSPEED, CMD_SETSPEED};
            errors = 0;
            mode   = MODE_OFF;
            clear_line();
        endfunction

        function void clear_line();
            char_count = 0;
            in_arg     = 1'b0;
            str_ended  = 1'b0;
            alive      = '1;
            phase      = NUM_SKIP;
            negative   = 1'b0;
            accum      = '0;
        endfunction

        // The command word is finished: only keywords of its length survive.
        function void keep_len(input int word_len);
            for (int k = 0; k < KW_COUNT; k++)
            begin
                if (kw_word[k].len() != word_len)
                    alive[k] = 1'b0;
            end
        endfunction

        function void match_at(input int pos, input logic [7:0] c);
            for (int k = 0; k < KW_COUNT; k++)
            begin
                if (pos >= kw_word[k].len() || kw_word[k][pos] != c)
                    alive[k] = 1'b0;
            end
        endfunction

        // Argument scan with atoi rules, accumulated modulo 2^16.
        function void digit_step(input logic [7:0] c);
            bit is_digit;
            is_digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
            if (phase == NUM_SKIP)
            begin
                if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))
                    return;
                if (c == CHAR_PLUS || c == CHAR_MINUS)
                begin
                    negative = (c == CHAR_MINUS);
                    phase    = NUM_SIGNED;
                    return;
                end
                phase = NUM_SIGNED;
            end
            if (phase == NUM_SIGNED || phase == NUM_DIGITS)
            begin
                if (is_digit)
                begin
                    accum = accum * 16'd10 + 16'(c - CHAR_ZERO);
                    phase = NUM_DIGITS;
                end
                else
                begin
                    phase = NUM_DONE;
                end
            end
        endfunction

        // Called for every byte transfer into the block, in order.
        function void note_byte(input logic [7:0] c);
            line_result_t r;
            logic [2:0]   code;
            bit           full;
            full = (char_count >= LINE_BUFFER_BYTES - 1);
            if (c == CHAR_NL || full)
            begin
                if (!str_ended && !in_arg)
                    keep_len(char_count);
                code = CMD_NO_MATCH;
                for (int k = KW_COUNT - 1; k >= 0; k--)
                begin
                    if (alive[k])
                        code = kw_cmd[k];
                end
                case (code)
                    CMD_STOP: mode = MODE_STOP;
                    CMD_OFF:  mode = MODE_OFF;
                    CMD_CW:   mode = MODE_CW;
                    CMD_CCW:  mode = MODE_CCW;
                    default:  ;
                endcase
                r.command_code   = code;
                r.drive_mode     = mode;
                r.speed_valid    = (code == CMD_SETSPEED);
                r.speed_value    = '0;
                if (code == CMD_SETSPEED)
                    r.speed_value = negative ? 16'd0 - accum : accum;
                r.line_truncated = (c != CHAR_NL);
                line_results_due.push_back(r);
                clear_line();
                return;
            end
            if (!str_ended)
            begin
                if (c == CHAR_NUL)
                begin
                    if (!in_arg)
                        keep_len(char_count);
                    str_ended = 1'b1;
                end
                else if (!in_arg)
                begin
                    if (c == CHAR_SPACE)
                    begin
                        keep_len(char_count);
                        in_arg = 1'b1;
                    end
                    else
                    begin
                        match_at(char_count, c);
                    end
                end
                else
                begin
                    digit_step(c);
                end
            end
            char_count++;
        endfunction

        function void compare_field(input string name, input logic [15:0] want,
                                    input logic [15:0] got, input longint unsigned stamp);
            if (got !== want)
            begin
                $display("%0d ns: %s mismatch, expected %0d, actual %0d",
                         stamp, name, want, got);
                errors++;
            end
        endfunction

        // Called for every result transfer out of the block.
        function void check_line_result(input line_result_t got,
                                        input longint unsigned stamp);
            line_result_t want;
            if (line_results_due.size() == 0)
            begin
                $display("%0d ns: result with none due, expected nothing, actual %h",
                         stamp, got);
                errors++;
                return;
            end
            want = line_results_due.pop_front();
            compare_field("command_code", want.command_code, got.command_code, stamp);
            compare_field("drive_mode", want.drive_mode, got.drive_mode, stamp);
            compare_field("speed_value", want.speed_value, got.speed_value, stamp);
            compare_field("speed_valid", want.speed_valid, got.speed_valid, stamp);
            compare_field("line_truncated", want.line_truncated, got.line_truncated, stamp);
        endfunction

        function int lines_due();
            return line_results_due.size();
        endfunction

    endclass

endpackage

FILE: tb/tb_top.sv
// ============================================================================
// tb_top: bench of the text command line parser
// Feeds directed command lines, then random well-formed, near-miss, noisy and
// overlong lines through the byte channel under random idling and stalls,
// and checks every line result against a scoreboard that tracks the parser.
// ============================================================================

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tcl_pkg::*;
    import line_parser_check_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_BYTES   = 1480;
    localparam int IDLE_PERCENT   = 14;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 10;

    localparam logic [7:0] CHAR_VT = 8'd11;
    localparam logic [7:0] CHAR_FF = 8'd12;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  command_code;
    logic [1:0]  drive_mode;
    logic [15:0] speed_value;
    logic        speed_valid;
    logic        line_truncated;

    line_parser_scoreboard lines_sb;
    logic [7:0]            line_buf[$];
    bit                    no_idle;
    bit                    rx_hold_req;
    int                    bytes_sent;

    text_command_line_parser #(
        .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .command_code   (command_code),
        .drive_mode     (drive_mode),
        .speed_value    (speed_value),
        .speed_valid    (speed_valid),
        .line_truncated (line_truncated)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            lines_sb.check_line_result({command_code, drive_mode, speed_value,
                                        speed_valid, line_truncated}, $time);
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        lines_sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    task automatic send_line(input string s);
        send_text(s);
        send_byte(CHAR_NL);
    endtask

    task automatic flush_line_buf();
        foreach (line_buf[i])
        begin
            send_byte(line_buf[i]);
        end
        line_buf.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            line_buf.push_back(s[i]);
        end
    endtask

    // Hold the channel empty until every line result has come out.
    task automatic wait_for_lines();
        in_valid <= 1'b0;
        while (lines_sb.lines_due() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(4))
            0:       return CHAR_TAB;
            1:       return CHAR_VT;
            2:       return CHAR_FF;
            3:       return CHAR_CR;
            default: return CHAR_SPACE;
        endcase
    endfunction

    task automatic push_argument();
        line_buf.push_back(CHAR_SPACE);
        repeat ($urandom_range(2)) line_buf.push_back(pick_blank());
        case ($urandom_range(3))
            0:       line_buf.push_back(CHAR_PLUS);
            1:       line_buf.push_back(CHAR_MINUS);
            default: ;
        endcase
        repeat ($urandom_range(7)) line_buf.push_back(CHAR_ZERO + 8'($urandom_range(9)));
        if ($urandom_range(3) == 0)
            line_buf.push_back(8'($urandom_range(32, 126)));
    endtask

    task automatic send_random_line();
        int pick;
        int k;
        pick = $urandom_range(99);
        k    = $urandom_range(KW_COUNT);
        if (k == KW_COUNT)
            k = KW_COUNT - 1;
        if (pick < 60)
        begin
            push_text(keyword_name(k));
            if ((k == KW_COUNT - 1 && $urandom_range(9) != 0) || $urandom_range(4) == 0)
                push_argument();
        end
        else if (pick < 75)
        begin
            push_text(keyword_name(k));
            case ($urandom_range(2))
                0:       line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
                1:       void'(line_buf.pop_back());
                default: line_buf.push_back(8'($urandom_range(97, 122)));
            endcase
            if ($urandom_range(1) == 0)
                push_argument();
        end
        else if (pick < 96)
        begin
            repeat ($urandom_range(12)) line_buf.push_back(8'($urandom_range(255)));
        end
        else
        begin
            // Long line that may fill the buffer.
            if ($urandom_range(1) == 0)
                push_text("setspeed ");
            repeat ($urandom_range(55, 75))
                line_buf.push_back(8'($urandom_range(32, 126)));
        end
        if (pick < 75 && $urandom_range(11) == 0)
            line_buf.insert($urandom_range(line_buf.size()), CHAR_NUL);
        if (pick < 96 || $urandom_range(1) == 0)
            line_buf.push_back(CHAR_NL);
        flush_line_buf();
    endtask

    initial
    begin
        int  rand_start;
        bit  hold_done;
        bit  pause_done;
        lines_sb    = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        rx_byte     = '0;
        no_idle     = 1'b0;
        rx_hold_req = 1'b0;
        bytes_sent  = 0;
        hold_done   = 1'b0;
        pause_done  = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_line("stop");
        send_line("off");
        send_line("cw");
        send_line("ccw");
        send_line("getspeed");
        send_line("setspeed 1234");
        send_line("setspeed");
        send_line("");
        send_line(" cw");
        send_line("setspeed -5");
        send_line("setspeed +70000");
        send_line("setspeed 4294967295");
        send_text("setspeed ");
        send_byte(CHAR_TAB);
        send_byte(CHAR_VT);
        send_byte(CHAR_FF);
        send_byte(CHAR_CR);
        send_line("-99x12");
        send_line("sto");
        send_line("stopp");
        send_line("ccw extra");
        send_line("setspeed --3");
        // A zero byte ends the string: the word before it still counts.
        send_text("cw");
        send_byte(CHAR_NUL);
        send_line("junk");
        send_text("set");
        send_byte(CHAR_NUL);
        send_line("speed 5");
        send_text("setspeed 12");
        send_byte(CHAR_NUL);
        send_line("34");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(CHAR_NL);
        // Buffer full just as the newline arrives: no truncation mark.
        send_text("ccw ");
        repeat (LINE_BUFFER_BYTES - 5) send_byte("7");
        send_byte(CHAR_NL);
        // Buffer full with another byte arriving: that byte is dropped.
        send_text("setspeed ");
        repeat (LINE_BUFFER_BYTES - 10) send_byte("9");
        send_byte("x");
        send_line("off");
        wait_for_lines();

        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RANDOM_BYTES)
        begin
            if (!hold_done && bytes_sent - rand_start >= 500)
            begin
                rx_hold_req = 1'b1;
                hold_done   = 1'b1;
            end
            no_idle = (bytes_sent - rand_start >= 900 && bytes_sent - rand_start < 1300);
            if (!pause_done && bytes_sent - rand_start >= 1350)
            begin
                wait_for_lines();
                pause_done = 1'b1;
            end
            send_random_line();
        end

        wait_for_lines();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (lines_sb.errors == 0 && lines_sb.lines_due() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/tcl_pkg.sv
rtl/tcl_parse_core.sv
rtl/tcl_out_stage.sv
rtl/text_command_line_parser.sv
rtl/tcl_checker.sv
tb/line_parser_check_pkg.sv
tb/tb_top.sv
